// ===== rtl/tctg_pkg.sv =====
// Shared types and constants for the three-color chase trail generator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tctg_pkg;

    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int TRAIL_W = 5;
    localparam int SPACE_W = 6;
    localparam int TOTAL_W = 9;
    localparam int BYTE_W  = 8;
    localparam int MUL_W   = 9;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ADDR_W  = 3;

    localparam logic [ADDR_W-1:0] REG_LED_COUNT       = 3'd0;
    localparam logic [ADDR_W-1:0] REG_TRAIL_LENGTH    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_COLOR_GAP       = 3'd2;
    localparam logic [ADDR_W-1:0] REG_FADE_STEP       = 3'd3;
    localparam logic [ADDR_W-1:0] REG_FRAMES_PER_STEP = 3'd4;
    localparam logic [ADDR_W-1:0] REG_TARGET_CYCLES   = 3'd5;

    // Effective configuration after clamping, as the datapath sees it.
    typedef struct packed {
        logic [CNT_W-1:0]   led_num;
        logic [TRAIL_W-1:0] trail;
        logic [SPACE_W-1:0] spacing;
        logic [TOTAL_W-1:0] total;
        logic [BYTE_W-1:0]  fade_step;
        logic [BYTE_W-1:0]  frames_per_step;
        logic [BYTE_W-1:0]  target;
    } tctg_cfg_t;

    // Per-frame status latched when a tick beat is taken.
    typedef struct packed {
        logic [BYTE_W-1:0] step;
        logic              running;
        logic [BYTE_W-1:0] cycles_done;
    } tctg_frame_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_AMOUNT,
        ST_RED,
        ST_GREEN,
        ST_BLUE,
        ST_EMIT
    } tctg_state_t;

endpackage

`default_nettype wire

// ===== rtl/three_color_chase_trail_generator.sv =====
// Top level of the three-color chase trail generator: configuration
// registers, tick state and pixel sequencer. Depends on tctg_pkg,
// tctg_tick, tctg_pixel_seq and tctg_mul.
//
//   Channel  Direction  Beat contents
//   s_       in         one frame tick with three head colors
//   m_       out        one pixel per LED, tlast on the final LED
//   cfg_     in         register write, index and data
//
// A tick beat is taken only while the sequencer is idle. Each LED then steps
// through select, fade amount, red, green and blue, sharing the single
// multiplier, and then emit, which waits while m_tready stalls the output. The
// output register lets the next tick be taken while the last pixel still waits.
// Reset is synchronous and restores the register defaults and clears step,
// divider and pass count.
`timescale 1ns / 1ps
`default_nettype none

module three_color_chase_trail_generator
    import tctg_pkg::*;
#(
    parameter int MAX_LEDS  = 64,
    parameter int MAX_TRAIL = 31
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // head_color_a [23:0], head_color_b [47:24], head_color_c [71:48]
    input  wire logic [71:0]       s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // pixel_index [5:0], pixel_red [13:6], pixel_green [21:14],
    // pixel_blue [29:22], still_running [30], cycles_done [38:31], zero [39]
    output logic [39:0]            m_tdata,
    output logic                   m_tlast,
    input  wire logic              cfg_wr_en,
    input  wire logic [ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0] cfg_wdata
);

    logic [CNT_W-1:0]   led_count_reg;
    logic [TRAIL_W-1:0] trail_length_reg;
    logic [TRAIL_W-1:0] color_gap_reg;
    logic [BYTE_W-1:0]  fade_step_reg;
    logic [BYTE_W-1:0]  frames_per_step_reg;
    logic [BYTE_W-1:0]  target_cycles_reg;

    tctg_cfg_t   cfg;
    tctg_frame_t frame;
    logic [IDX_W-1:0]  px_index;
    logic [CHAN_W-1:0] px_red, px_green, px_blue;
    logic              px_running;
    logic [BYTE_W-1:0] px_cycles;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg       <= 7'd64;
            trail_length_reg    <= 5'd5;
            color_gap_reg       <= 5'd2;
            fade_step_reg       <= 8'd40;
            frames_per_step_reg <= 8'd1;
            target_cycles_reg   <= 8'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LED_COUNT:       led_count_reg       <= cfg_wdata[CNT_W-1:0];
                REG_TRAIL_LENGTH:    trail_length_reg    <= cfg_wdata[TRAIL_W-1:0];
                REG_COLOR_GAP:       color_gap_reg       <= cfg_wdata[TRAIL_W-1:0];
                REG_FADE_STEP:       fade_step_reg       <= cfg_wdata;
                REG_FRAMES_PER_STEP: frames_per_step_reg <= cfg_wdata;
                REG_TARGET_CYCLES:   target_cycles_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Zero LEDs behaves as one; counts and trails beyond the limits are clamped.
    always_comb begin
        if (led_count_reg == '0) begin
            cfg.led_num = 7'd1;
        end else if (led_count_reg > CNT_W'(MAX_LEDS)) begin
            cfg.led_num = CNT_W'(MAX_LEDS);
        end else begin
            cfg.led_num = led_count_reg;
        end
        if (7'(trail_length_reg) > 7'(MAX_TRAIL)) begin
            cfg.trail = TRAIL_W'(MAX_TRAIL);
        end else begin
            cfg.trail = trail_length_reg;
        end
        cfg.spacing         = SPACE_W'(cfg.trail) + SPACE_W'(color_gap_reg);
        cfg.total           = TOTAL_W'(cfg.led_num) + TOTAL_W'({cfg.spacing, 1'b0})
                              + TOTAL_W'(cfg.trail);
        cfg.fade_step       = fade_step_reg;
        cfg.frames_per_step = frames_per_step_reg;
        cfg.target          = target_cycles_reg;
    end

    tctg_tick u_tick (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tick_acc (s_tvalid && s_tready),
        .cfg      (cfg),
        .frame    (frame)
    );

    tctg_pixel_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .frame     (frame),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_colors  (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_index   (px_index),
        .m_red     (px_red),
        .m_green   (px_green),
        .m_blue    (px_blue),
        .m_last    (m_tlast),
        .m_running (px_running),
        .m_cycles  (px_cycles)
    );

    assign m_tdata = {1'b0, px_cycles, px_running, px_blue, px_green, px_red, px_index};

endmodule

`default_nettype wire

// ===== rtl/tctg_mul.sv =====
// Shared 9x9 unsigned multiplier with a registered product.
// Depends on tctg_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module tctg_mul
    import tctg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [MUL_W-1:0]  op_a,
    input  wire logic [MUL_W-1:0]  op_b,
    output logic      [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/tctg_tick.sv =====
// Frame divider, step position and pass counter, updated once per tick beat.
// Depends on tctg_pkg for the configuration and frame status structs.
`timescale 1ns / 1ps
`default_nettype none

module tctg_tick
    import tctg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        tick_acc,
    input  wire tctg_cfg_t   cfg,
    output tctg_frame_t      frame
);

    logic [BYTE_W-1:0] step_reg, step_next;
    logic [BYTE_W-1:0] div_reg, div_next;
    logic [BYTE_W-1:0] passes_reg, passes_next;
    tctg_frame_t       frame_reg, frame_next;

    logic [BYTE_W:0]    div_sum;
    logic               advance;
    logic [TOTAL_W-1:0] step_adv;
    logic               wrap;

    always_comb begin
        div_sum   = {1'b0, div_reg} + 9'd1;
        advance   = div_sum >= {1'b0, cfg.frames_per_step};
        step_adv  = advance ? ({1'b0, step_reg} + 9'd1) : {1'b0, step_reg};
        wrap      = step_adv >= cfg.total;

        div_next    = advance ? '0 : div_sum[BYTE_W-1:0];
        step_next   = step_adv[BYTE_W-1:0];
        passes_next = passes_reg;
        if (wrap) begin
            div_next  = '0;
            step_next = '0;
            if (passes_reg != 8'hFF) begin
                passes_next = passes_reg + 8'd1;
            end
        end

        // Rendering of this frame uses the step held before the update.
        frame_next.step        = step_reg;
        frame_next.cycles_done = passes_next;
        frame_next.running     = !(wrap && (passes_next >= cfg.target));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            div_reg    <= '0;
            passes_reg <= '0;
            frame_reg  <= '0;
        end else if (tick_acc) begin
            step_reg   <= step_next;
            div_reg    <= div_next;
            passes_reg <= passes_next;
            frame_reg  <= frame_next;
        end
    end

    assign frame = frame_reg;

endmodule

`default_nettype wire

// ===== rtl/tctg_pixel_seq.sv =====
// Pixel sequencer: walks the LEDs of one frame, picks the winning head for
// each, and fades its channels through the shared multiplier.
// Depends on tctg_pkg and tctg_mul.
`timescale 1ns / 1ps
`default_nettype none

module tctg_pixel_seq
    import tctg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire tctg_cfg_t              cfg,
    input  wire tctg_frame_t            frame,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [3*COLOR_W-1:0]   s_colors,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [IDX_W-1:0]            m_index,
    output logic [CHAN_W-1:0]           m_red,
    output logic [CHAN_W-1:0]           m_green,
    output logic [CHAN_W-1:0]           m_blue,
    output logic                        m_last,
    output logic                        m_running,
    output logic [BYTE_W-1:0]           m_cycles
);

    tctg_state_t state_reg, state_next;

    logic [3*COLOR_W-1:0] cols_reg;
    logic [IDX_W-1:0]     pix_reg;
    logic [COLOR_W-1:0]   win_reg;
    logic [TRAIL_W-1:0]   dist_reg;
    logic [MUL_W-1:0]     inv_reg;
    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    green_reg;

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_index_reg;
    logic [CHAN_W-1:0]    out_red_reg, out_green_reg, out_blue_reg;
    logic                 out_last_reg, out_running_reg;
    logic [BYTE_W-1:0]    out_cycles_reg;

    logic                 mul_en;
    logic [MUL_W-1:0]     mul_a, mul_b;
    logic [PROD_W-1:0]    prod;
    logic [MUL_W-1:0]     inv_amt;
    logic                 out_free;
    logic                 out_load;
    logic                 pix_last;
    logic                 tick_acc;

    logic [COLOR_W-1:0]   sel_col;
    logic [TRAIL_W-1:0]   sel_dist;
    logic [CNT_W-1:0]     head_off [3];
    logic [BYTE_W-1:0]    head_pos;
    logic [BYTE_W-1:0]    trail_dist;

    tctg_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    assign inv_amt  = 9'd256 - {1'b0, prod[BYTE_W-1:0]};
    assign out_free = !out_valid_reg || m_tready;
    assign pix_last = ({1'b0, pix_reg} + 7'd1) == cfg.led_num;
    assign tick_acc = s_tvalid && s_tready;

    // Head selection: later colors overwrite earlier ones where trails overlap.
    always_comb begin
        sel_col  = '0;
        sel_dist = '0;
        head_off[0] = '0;
        head_off[1] = CNT_W'(cfg.spacing);
        head_off[2] = {cfg.spacing, 1'b0};
        head_pos   = '0;
        trail_dist = '0;
        for (int k = 0; k < 3; k++) begin
            head_pos   = frame.step - BYTE_W'(head_off[k]);
            trail_dist = head_pos - BYTE_W'(pix_reg);
            if ((frame.step >= BYTE_W'(head_off[k])) && (head_pos >= BYTE_W'(pix_reg))
                && (trail_dist <= BYTE_W'(cfg.trail))) begin
                sel_col  = cols_reg[k*COLOR_W +: COLOR_W];
                sel_dist = trail_dist[TRAIL_W-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT: begin
                state_next = ST_AMOUNT;
            end
            ST_AMOUNT: begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(dist_reg);
                mul_b      = {1'b0, cfg.fade_step};
                state_next = ST_RED;
            end
            ST_RED: begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, win_reg[23:16]};
                mul_b      = inv_amt;
                state_next = ST_GREEN;
            end
            ST_GREEN: begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, win_reg[15:8]};
                mul_b      = inv_reg;
                state_next = ST_BLUE;
            end
            ST_BLUE: begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, win_reg[7:0]};
                mul_b      = inv_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = pix_last ? ST_IDLE : ST_SELECT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            cols_reg <= s_colors;
            pix_reg  <= '0;
        end
        if (state_reg == ST_SELECT) begin
            win_reg  <= sel_col;
            dist_reg <= sel_dist;
        end
        if (state_reg == ST_RED) begin
            inv_reg <= inv_amt;
        end
        if (state_reg == ST_GREEN) begin
            red_reg <= prod[2*CHAN_W-1:CHAN_W];
        end
        if (state_reg == ST_BLUE) begin
            green_reg <= prod[2*CHAN_W-1:CHAN_W];
        end
        if (out_load) begin
            out_index_reg   <= pix_reg;
            out_red_reg     <= red_reg;
            out_green_reg   <= green_reg;
            out_blue_reg    <= prod[2*CHAN_W-1:CHAN_W];
            out_last_reg    <= pix_last;
            out_running_reg <= frame.running;
            out_cycles_reg  <= frame.cycles_done;
            pix_reg         <= pix_reg + 6'd1;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_index   = out_index_reg;
    assign m_red     = out_red_reg;
    assign m_green   = out_green_reg;
    assign m_blue    = out_blue_reg;
    assign m_last    = out_last_reg;
    assign m_running = out_running_reg;
    assign m_cycles  = out_cycles_reg;

endmodule

`default_nettype wire
